[hw/rtl/mcmt_pkg.sv]
// ----------------------------------------------------------------------------
// mcmt_pkg - shared constants and tables
// widths, register indexes and the arctangent table of the cone test
// ----------------------------------------------------------------------------
package mcmt_pkg;

  localparam int ROOT_W    = 34;          // width of floor(sqrt(range^2))
  localparam int SQ_W      = 2 * ROOT_W;  // radicand width
  localparam int DVD_W     = 52;          // width of the projected terms
  localparam int QUO_W     = 15;          // quotient holds 0 .. 16384
  localparam int CORD_W    = 54;          // cordic datapath width
  localparam int ANG_W     = 17;          // Q2.13 angle plus headroom
  localparam int CORD_ITERS = 14;
  localparam int MAX_STEPS = 4096;

  localparam int HALF_PI_Q13 = 12868;
  localparam int ONE_Q14     = 16384;
  localparam int ONE_SQ_Q28  = 268435456;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_DURATION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIND      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOXEL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_EL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_EL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EL_LIMITS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_AZ   = 3'd7;

  // arctangent of 2^-i in Q2.13
  function automatic logic signed [ANG_W-1:0] atan_q13(input logic [3:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      4'd0:    v = 17'sd6434;
      4'd1:    v = 17'sd3798;
      4'd2:    v = 17'sd2007;
      4'd3:    v = 17'sd1019;
      4'd4:    v = 17'sd511;
      4'd5:    v = 17'sd256;
      4'd6:    v = 17'sd128;
      4'd7:    v = 17'sd64;
      4'd8:    v = 17'sd32;
      4'd9:    v = 17'sd16;
      4'd10:   v = 17'sd8;
      4'd11:   v = 17'sd4;
      4'd12:   v = 17'sd2;
      4'd13:   v = 17'sd1;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/mcmt_sqrt.sv]
// ----------------------------------------------------------------------------
// mcmt_sqrt - iterative integer square root
// floor(sqrt(x)) one result bit per cycle, digit-by-digit remainder method
// ----------------------------------------------------------------------------
module mcmt_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mcmt_pkg::SQ_W-1:0]     rad_in,
  output logic                          done,
  output logic [mcmt_pkg::ROOT_W-1:0]   root
);

  logic [mcmt_pkg::SQ_W-1:0]   rad_r;
  logic [mcmt_pkg::ROOT_W+3:0] rem_r;
  logic [mcmt_pkg::ROOT_W-1:0] root_r;
  logic [5:0]                  cnt_r;
  logic                        busy_r;
  logic                        done_r;

  logic [mcmt_pkg::ROOT_W+3:0] rem_s;
  logic [mcmt_pkg::ROOT_W+3:0] trial;
  logic                        ge;

  assign rem_s = {rem_r[mcmt_pkg::ROOT_W+1:0], rad_r[mcmt_pkg::SQ_W-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = rem_s >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(mcmt_pkg::ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad_in;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[mcmt_pkg::SQ_W-3:0], 2'b00};
      if (ge) begin
        rem_r  <= rem_s - trial;
        root_r <= {root_r[mcmt_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_s;
        root_r <= {root_r[mcmt_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[hw/rtl/mcmt_div.sv]
// ----------------------------------------------------------------------------
// mcmt_div - iterative restoring divider
// 15-bit quotient, one bit per cycle; caller guarantees quotient < 2^15
// ----------------------------------------------------------------------------
module mcmt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mcmt_pkg::DVD_W-1:0]    dividend,
  input  logic [mcmt_pkg::ROOT_W-1:0]   divisor,
  output logic                          done,
  output logic [mcmt_pkg::QUO_W-1:0]    quot
);

  localparam int PAD = mcmt_pkg::DVD_W - mcmt_pkg::ROOT_W - (mcmt_pkg::QUO_W - 1);

  logic [mcmt_pkg::DVD_W-1:0] rem_r;
  logic [mcmt_pkg::DVD_W-1:0] dsh_r;
  logic [mcmt_pkg::QUO_W-1:0] quot_r;
  logic [3:0]                 cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic                       ge;

  assign ge = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(mcmt_pkg::QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      dsh_r  <= {{PAD{1'b0}}, divisor, {(mcmt_pkg::QUO_W-1){1'b0}}};
      quot_r <= '0;
    end else if (busy_r) begin
      dsh_r <= {1'b0, dsh_r[mcmt_pkg::DVD_W-1:1]};
      if (ge) begin
        rem_r  <= rem_r - dsh_r;
        quot_r <= {quot_r[mcmt_pkg::QUO_W-2:0], 1'b1};
      end else begin
        quot_r <= {quot_r[mcmt_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[hw/rtl/mcmt_cordic.sv]
// ----------------------------------------------------------------------------
// mcmt_cordic - vectoring cordic atan2
// quarter-turn pre-rotation for negative x, then one iteration per cycle
// ----------------------------------------------------------------------------
module mcmt_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [mcmt_pkg::CORD_W-1:0]  y_in,
  input  logic signed [mcmt_pkg::CORD_W-1:0]  x_in,
  output logic                                done,
  output logic signed [mcmt_pkg::ANG_W-1:0]   ang
);

  logic signed [mcmt_pkg::CORD_W-1:0] x_r;
  logic signed [mcmt_pkg::CORD_W-1:0] y_r;
  logic signed [mcmt_pkg::ANG_W-1:0]  ang_r;
  logic [3:0]                         it_r;
  logic                               busy_r;
  logic                               done_r;
  logic                               zero_in;

  logic signed [mcmt_pkg::CORD_W-1:0] xs;
  logic signed [mcmt_pkg::CORD_W-1:0] ys;

  assign zero_in = (x_in == '0) && (y_in == '0);
  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        it_r <= '0;
        if (zero_in) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        it_r <= it_r + 4'd1;
        if (it_r == 4'(mcmt_pkg::CORD_ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (zero_in) begin
        ang_r <= '0;
        x_r   <= x_in;
        y_r   <= y_in;
      end else if (x_in < 0) begin
        if (y_in >= 0) begin
          x_r   <= y_in;
          y_r   <= -x_in;
          ang_r <= 17'(mcmt_pkg::HALF_PI_Q13);
        end else begin
          x_r   <= -y_in;
          y_r   <= x_in;
          ang_r <= -17'(mcmt_pkg::HALF_PI_Q13);
        end
      end else begin
        x_r   <= x_in;
        y_r   <= y_in;
        ang_r <= '0;
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_r   <= x_r + ys;
        y_r   <= y_r - xs;
        ang_r <= ang_r + mcmt_pkg::atan_q13(it_r);
      end else begin
        x_r   <= x_r - ys;
        y_r   <= y_r + xs;
        ang_r <= ang_r - mcmt_pkg::atan_q13(it_r);
      end
    end
  end

  assign done = done_r;
  assign ang  = ang_r;

endmodule

[hw/rtl/moving_cone_membership_test.sv]
// ----------------------------------------------------------------------------
// moving_cone_membership_test - point in drifting observing cone
// sequencer over one shared multiplier, a square root, a divider and a cordic
// ----------------------------------------------------------------------------
// usage:
//  - input channel (in_valid/in_ready) carries one point (Q23.8) plus the
//    single_time flag and time_step; in_ready is high only while idle
//  - result channel (out_valid/out_ready) carries one bit, out_inside_res,
//    per point; the result register lets the sequencer return to idle and
//    take the next point while an earlier result still waits
//  - cfg_we/cfg_index/cfg_data write one register per cycle; the user must
//    write only while idle, the block itself does not enforce it
//  - a checked step ends soonest for a point behind the voxel, later for a
//    range or near-axis decision, and last when both the elevation and
//    azimuth angles are needed; the square root (run twice) and the two
//    cordic passes take most of its time
//  - a sweep runs the steps in turn until one accepts or the last is done
//  - reset clears the sequencer and the result valid and loads the register
//    reset values (cosine 1.0, all others zero)
//  - if the receiver stalls, a finished result waits in the final state
//    until the result register frees up
// ----------------------------------------------------------------------------
module moving_cone_membership_test (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [mcmt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcmt_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [31:0]                  in_point_x,
  input  logic signed [31:0]                  in_point_y,
  input  logic signed [31:0]                  in_point_z,
  input  logic                                in_single_time,
  input  logic [11:0]                         in_time_step,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_inside_res
);

  localparam int NS = 29;

  typedef enum logic [NS-1:0] {
    ST_IDLE = 29'd1 << 0,
    ST_WX   = 29'd1 << 1,
    ST_WY   = 29'd1 << 2,
    ST_WZ   = 29'd1 << 3,
    ST_SQX  = 29'd1 << 4,
    ST_SQY  = 29'd1 << 5,
    ST_SQZ  = 29'd1 << 6,
    ST_SQA  = 29'd1 << 7,
    ST_SQS  = 29'd1 << 8,
    ST_SQW  = 29'd1 << 9,
    ST_RNG  = 29'd1 << 10,
    ST_DZ1  = 29'd1 << 11,
    ST_DZ2  = 29'd1 << 12,
    ST_DZ3  = 29'd1 << 13,
    ST_DZ4  = 29'd1 << 14,
    ST_DVW  = 29'd1 << 15,
    ST_QSQ  = 29'd1 << 16,
    ST_QRT  = 29'd1 << 17,
    ST_QRW  = 29'd1 << 18,
    ST_CS1  = 29'd1 << 19,
    ST_CW1  = 29'd1 << 20,
    ST_DX1  = 29'd1 << 21,
    ST_DX2  = 29'd1 << 22,
    ST_DX3  = 29'd1 << 23,
    ST_CS2  = 29'd1 << 24,
    ST_CW2  = 29'd1 << 25,
    ST_PASS = 29'd1 << 26,
    ST_FAIL = 29'd1 << 27,
    ST_FIN  = 29'd1 << 28
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [11:0] duration_steps_r;
  logic [47:0] wind_velocity_r;
  logic [47:0] voxel_steps_r;
  logic [30:0] max_distance_r;
  logic [15:0] cos_elevation_r;
  logic [15:0] sin_elevation_r;
  logic [31:0] elevation_limits_r;
  logic [14:0] half_azimuth_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_steps_r     <= '0;
      wind_velocity_r      <= '0;
      voxel_steps_r        <= '0;
      max_distance_r       <= '0;
      cos_elevation_r      <= 16'(mcmt_pkg::ONE_Q14);
      sin_elevation_r      <= '0;
      elevation_limits_r   <= '0;
      half_azimuth_width_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mcmt_pkg::CFG_DURATION:  duration_steps_r     <= cfg_data[11:0];
        mcmt_pkg::CFG_WIND:      wind_velocity_r      <= cfg_data[47:0];
        mcmt_pkg::CFG_VOXEL:     voxel_steps_r        <= cfg_data[47:0];
        mcmt_pkg::CFG_MAX_DIST:  max_distance_r       <= cfg_data[30:0];
        mcmt_pkg::CFG_COS_EL:    cos_elevation_r      <= cfg_data[15:0];
        mcmt_pkg::CFG_SIN_EL:    sin_elevation_r      <= cfg_data[15:0];
        mcmt_pkg::CFG_EL_LIMITS: elevation_limits_r   <= cfg_data[31:0];
        mcmt_pkg::CFG_HALF_AZ:   half_azimuth_width_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // register fields
  logic signed [33:0] wx, wy, wz, ce, se;
  logic [15:0]        xs, ys, zs;
  logic signed [16:0] el_min, el_max;
  logic [12:0]        n_cap;

  assign wx = {{18{wind_velocity_r[15]}}, wind_velocity_r[15:0]};
  assign wy = {{18{wind_velocity_r[31]}}, wind_velocity_r[31:16]};
  assign wz = {{18{wind_velocity_r[47]}}, wind_velocity_r[47:32]};
  assign xs = voxel_steps_r[15:0];
  assign ys = voxel_steps_r[31:16];
  assign zs = voxel_steps_r[47:32];
  assign ce = {{18{cos_elevation_r[15]}}, cos_elevation_r};
  assign se = {{18{sin_elevation_r[15]}}, sin_elevation_r};
  assign el_min = {elevation_limits_r[15], elevation_limits_r[15:0]};
  assign el_max = {elevation_limits_r[31], elevation_limits_r[31:16]};
  // sweep length, capped at the step limit
  assign n_cap = ({1'b0, duration_steps_r} > 13'(mcmt_pkg::MAX_STEPS)) ?
                 13'(mcmt_pkg::MAX_STEPS) : {1'b0, duration_steps_r};

  // item and working registers
  logic signed [31:0] px_r, py_r, pz_r;
  logic               single_r;
  logic [11:0]        t_r;
  logic signed [32:0] dx_r, dy_r, dz_r;
  logic signed [33:0] dzp_r;
  logic [mcmt_pkg::SQ_W-1:0]   sum_r;
  logic [mcmt_pkg::ROOT_W-1:0] r_r;
  logic signed [mcmt_pkg::DVD_W-1:0] prod_r;
  logic [mcmt_pkg::QUO_W-1:0]  qm_r;
  logic [15:0]                 c_r;
  logic                        res_r;
  logic                        out_valid_r;
  logic                        out_res_r;

  // shared multiplier, registered product
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p, mul_r;
  logic signed [33:0] dxs;

  assign dxs = {dx_r[32], dx_r} + {18'b0, xs};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_WX:  begin mul_a = wx; mul_b = {22'b0, t_r}; end
      ST_WY:  begin mul_a = wy; mul_b = {22'b0, t_r}; end
      ST_WZ:  begin mul_a = wz; mul_b = {22'b0, t_r}; end
      ST_SQX: begin mul_a = {dx_r[32], dx_r}; mul_b = {dx_r[32], dx_r}; end
      ST_SQY: begin mul_a = {dy_r[32], dy_r}; mul_b = {dy_r[32], dy_r}; end
      ST_SQZ: begin mul_a = {dz_r[32], dz_r}; mul_b = {dz_r[32], dz_r}; end
      ST_DZ1: begin mul_a = {dx_r[32], dx_r}; mul_b = se; end
      ST_DZ2: begin mul_a = dzp_r; mul_b = ce; end
      ST_QSQ: begin mul_a = {19'b0, qm_r}; mul_b = {19'b0, qm_r}; end
      ST_DX1: begin mul_a = dxs; mul_b = ce; end
      ST_DX2: begin mul_a = dzp_r; mul_b = se; end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    mul_r <= mul_p;
  end

  // step decisions
  logic [32:0] dy_mag;
  logic [33:0] dzp_mag;
  logic        near;
  logic [41:0] r100, m101;
  logic        too_far;
  logic [mcmt_pkg::DVD_W-1:0] dzz_mag;
  logic [mcmt_pkg::DVD_W:0]   sat_lim;
  logic                       q_sat;
  logic                       last_step;
  logic signed [33:0]         dz_ext;
  logic signed [15:0]         q_s;
  logic [16:0]                az_mag;

  assign dy_mag  = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
  assign dzp_mag = dzp_r[33] ? 34'(-dzp_r) : 34'(dzp_r);
  assign near    = (dy_mag < {16'b0, ys, 1'b0}) && (dzp_mag < {17'b0, zs, 1'b0});
  assign r100    = 42'(r_r) * 42'd100;
  assign m101    = 42'(max_distance_r) * 42'd101;
  assign too_far = r100 > m101;
  assign dzz_mag = prod_r[mcmt_pkg::DVD_W-1] ? mcmt_pkg::DVD_W'(-prod_r)
                                             : mcmt_pkg::DVD_W'(prod_r);
  // quotient above one when |dzz| >= 16385 * r
  assign sat_lim = ((mcmt_pkg::DVD_W+1)'(r_r) << 14) + (mcmt_pkg::DVD_W+1)'(r_r);
  assign q_sat   = {1'b0, dzz_mag} >= sat_lim;
  assign last_step = ({1'b0, t_r} + 13'd1) >= n_cap;
  assign dz_ext  = {dz_r[32], dz_r};
  assign q_s     = prod_r[mcmt_pkg::DVD_W-1] ? -{1'b0, qm_r} : {1'b0, qm_r};

  // shared units
  logic                          sqrt_start, sqrt_done;
  logic [mcmt_pkg::SQ_W-1:0]     sqrt_rad;
  logic [mcmt_pkg::ROOT_W-1:0]   sqrt_root;
  logic                          div_start, div_done;
  logic [mcmt_pkg::QUO_W-1:0]    div_quot;
  logic                          cord_start, cord_done;
  logic signed [mcmt_pkg::CORD_W-1:0] cord_y, cord_x;
  logic signed [mcmt_pkg::ANG_W-1:0]  cord_ang;

  assign sqrt_start = (state_r == ST_SQS) || (state_r == ST_QRT);
  // second root: sqrt(1 - q^2) in Q14
  assign sqrt_rad   = (state_r == ST_QRT) ?
                      mcmt_pkg::SQ_W'(mcmt_pkg::ONE_SQ_Q28) - $unsigned(mul_r) : sum_r;
  assign div_start  = (state_r == ST_DZ4) && (r_r != '0) && !q_sat;
  assign cord_start = (state_r == ST_CS1) || (state_r == ST_CS2);

  always_comb begin
    if (state_r == ST_CS2) begin
      cord_y = {{7{dy_r[32]}}, dy_r, 14'b0};
      cord_x = {{(mcmt_pkg::CORD_W-mcmt_pkg::DVD_W){prod_r[mcmt_pkg::DVD_W-1]}}, prod_r};
    end else begin
      cord_y = {{(mcmt_pkg::CORD_W-16){q_s[15]}}, q_s};
      cord_x = {{(mcmt_pkg::CORD_W-16){1'b0}}, c_r};
    end
  end

  assign az_mag = cord_ang[16] ? 17'(-cord_ang) : 17'(cord_ang);

  mcmt_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sqrt_start),
    .rad_in (sqrt_rad),
    .done   (sqrt_done),
    .root   (sqrt_root)
  );

  mcmt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dzz_mag),
    .divisor  (r_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  mcmt_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .y_in  (cord_y),
    .x_in  (cord_x),
    .done  (cord_done),
    .ang   (cord_ang)
  );

  // sequencer
  logic in_xfer;
  assign in_xfer = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (n_cap == '0) ? ST_FIN : ST_WX;
        end
      end
      ST_WX:  state_nxt = ST_WY;
      ST_WY:  state_nxt = ST_WZ;
      ST_WZ:  state_nxt = ST_SQX;
      // behind the voxel: reject before any range work
      ST_SQX: state_nxt = dxs[33] ? ST_FAIL : ST_SQY;
      ST_SQY: state_nxt = ST_SQZ;
      ST_SQZ: state_nxt = ST_SQA;
      ST_SQA: state_nxt = ST_SQS;
      ST_SQS: state_nxt = ST_SQW;
      ST_SQW: if (sqrt_done) state_nxt = ST_RNG;
      ST_RNG: begin
        if (too_far) begin
          state_nxt = ST_FAIL;
        end else if (near) begin
          state_nxt = ST_PASS;
        end else begin
          state_nxt = ST_DZ1;
        end
      end
      ST_DZ1: state_nxt = ST_DZ2;
      ST_DZ2: state_nxt = ST_DZ3;
      ST_DZ3: state_nxt = ST_DZ4;
      ST_DZ4: begin
        // zero range skips the elevation test
        if (r_r == '0) begin
          state_nxt = ST_DX1;
        end else if (q_sat) begin
          state_nxt = ST_QSQ;
        end else begin
          state_nxt = ST_DVW;
        end
      end
      ST_DVW: if (div_done) state_nxt = ST_QSQ;
      ST_QSQ: state_nxt = ST_QRT;
      ST_QRT: state_nxt = ST_QRW;
      ST_QRW: if (sqrt_done) state_nxt = ST_CS1;
      ST_CS1: state_nxt = ST_CW1;
      ST_CW1: begin
        if (cord_done) begin
          state_nxt = ((cord_ang < el_min) || (cord_ang > el_max)) ? ST_FAIL : ST_DX1;
        end
      end
      ST_DX1: state_nxt = ST_DX2;
      ST_DX2: state_nxt = ST_DX3;
      ST_DX3: state_nxt = ST_CS2;
      ST_CS2: state_nxt = ST_CW2;
      ST_CW2: begin
        if (cord_done) begin
          state_nxt = (az_mag > {2'b0, half_azimuth_width_r}) ? ST_FAIL : ST_PASS;
        end
      end
      ST_PASS: state_nxt = ST_FIN;
      ST_FAIL: state_nxt = (single_r || last_step) ? ST_FIN : ST_WX;
      ST_FIN:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_FIN) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          px_r     <= in_point_x;
          py_r     <= in_point_y;
          pz_r     <= in_point_z;
          single_r <= in_single_time;
          t_r      <= in_single_time ? in_time_step : 12'd0;
          res_r    <= 1'b0;
        end
      end
      ST_WY:  dx_r <= {px_r[31], px_r} - mul_r[32:0];
      ST_WZ:  dy_r <= {py_r[31], py_r} - mul_r[32:0];
      ST_SQX: dz_r <= {pz_r[31], pz_r} - mul_r[32:0];
      ST_SQY: sum_r <= $unsigned(mul_r);
      ST_SQZ: sum_r <= sum_r + $unsigned(mul_r);
      ST_SQA: begin
        sum_r <= sum_r + $unsigned(mul_r);
        // move dz by one voxel toward zero, or up by one voxel when dz is zero
        dzp_r <= (dz_r > 0) ? dz_ext - {18'b0, zs} : dz_ext + {18'b0, zs};
      end
      ST_SQW: if (sqrt_done) r_r <= sqrt_root;
      ST_DZ2: prod_r <= mul_r[mcmt_pkg::DVD_W-1:0];
      ST_DZ3: prod_r <= prod_r + mul_r[mcmt_pkg::DVD_W-1:0];
      ST_DZ4: if (q_sat) qm_r <= mcmt_pkg::QUO_W'(mcmt_pkg::ONE_Q14);
      ST_DVW: if (div_done) qm_r <= div_quot;
      ST_QRW: if (sqrt_done) c_r <= sqrt_root[15:0];
      ST_DX2: prod_r <= mul_r[mcmt_pkg::DVD_W-1:0];
      ST_DX3: prod_r <= prod_r - mul_r[mcmt_pkg::DVD_W-1:0];
      ST_PASS: res_r <= 1'b1;
      ST_FAIL: if (!(single_r || last_step)) t_r <= t_r + 12'd1;
      ST_FIN: if (!out_valid_r || out_ready) out_res_r <= res_r;
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_res_r;

endmodule
